>>> sv/iff_pkg.sv
package iff_pkg;

	// Default build of the formatter.
	localparam int FIELD_MAX_DEF  = 63;
	localparam int VALUE_BITS_DEF = 32;

	// Fixed field widths of the request and response items.
	localparam int KIND_W  = 1;
	localparam int VALUE_W = 33;
	localparam int WIDTH_W = 6;
	localparam int PREC_W  = 7;
	localparam int CHAR_W  = 8;
	localparam int DIGIT_W = 4;

	// Character positions in one field run from 0 to 63, and the count reaches 64.
	localparam int POS_W = 7;

	// Fixed characters of a field.
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

	// Digit characters, lower-case for hexadecimal.
	localparam logic [CHAR_W-1:0] DIGIT_TABLE [16] = '{
		"0", "1", "2", "3", "4", "5", "6", "7",
		"8", "9", "a", "b", "c", "d", "e", "f"
	};

	// Operation applied to every cell of the digit chain in the same cycle.
	typedef enum logic [1:0] {
		CH_HOLD,
		CH_LOAD,
		CH_DABBLE,
		CH_SHIFT
	} chain_op_t;

	typedef struct packed {
		chain_op_t op;
		logic      serial_bit;
	} chain_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DABBLE,
		ST_NORM,
		ST_SETUP,
		ST_EMIT
	} fmt_state_t;

	// Map a digit value to its ASCII character.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] nib);
		return DIGIT_TABLE[nib];
	endfunction

	// The chain needs enough cells for the decimal digits of 2^(vb-1) and for the
	// hexadecimal digits of a vb-bit word.
	function automatic int cell_count(input int vb);
		int dec_cells;
		int hex_cells;
		dec_cells = (vb * 3) / 10 + 1;
		hex_cells = (vb + 3) / 4;
		return (dec_cells > hex_cells) ? dec_cells : hex_cells;
	endfunction

endpackage

>>> sv/iff_ifs.sv
// Request channel: one integer with its conversion settings per item.
interface iff_req_if;
	import iff_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic signed [VALUE_W-1:0] value;
	logic [WIDTH_W-1:0]        width;
	logic signed [PREC_W-1:0]  precision;

	modport source (output valid, kind, value, width, precision, input ready);
	modport sink   (input valid, kind, value, width, precision, output ready);
endinterface

// Response channel: one character of the formatted field per item.
interface iff_chr_if;
	import iff_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] text_char;
	logic              last_char;

	modport source (output valid, text_char, last_char, input ready);
	modport sink   (input valid, text_char, last_char, output ready);
endinterface

>>> sv/iff_digit_cell.sv
module iff_digit_cell (
	input  logic                           clk,
	input  iff_pkg::chain_op_t             op,
	input  logic                           bit_in,
	input  logic [iff_pkg::DIGIT_W-1:0]    nib_in,
	input  logic [iff_pkg::DIGIT_W-1:0]    load_nib,
	output logic [iff_pkg::DIGIT_W-1:0]    digit,
	output logic                           carry
);
	import iff_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] corr;

	// Double-dabble correction: a digit of five or more gains three before the shift.
	assign corr  = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign carry = corr[DIGIT_W-1];
	assign digit = digit_q;

	// One digit of state, loaded, shifted in bitwise, or passed up whole.
	always_ff @(posedge clk) begin
		case (op)
			CH_LOAD:   digit_q <= load_nib;
			CH_DABBLE: digit_q <= {corr[DIGIT_W-2:0], bit_in};
			CH_SHIFT:  digit_q <= nib_in;
			default:   digit_q <= digit_q;
		endcase
	end

endmodule

>>> sv/iff_digit_chain.sv
module iff_digit_chain #(
	parameter int N_CELLS = 10
) (
	input  logic                                clk,
	input  iff_pkg::chain_ctrl_t                ctrl,
	input  logic [N_CELLS*iff_pkg::DIGIT_W-1:0] load_vec,
	output logic [iff_pkg::DIGIT_W-1:0]         top_digit
);
	import iff_pkg::*;

	logic [DIGIT_W-1:0] digit_w [N_CELLS];
	logic               carry_w [N_CELLS];

	// Cell 0 is the least significant digit; data moves towards the top cell.
	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		logic               bit_in;
		logic [DIGIT_W-1:0] nib_in;

		if (i == 0) begin : g_first
			assign bit_in = ctrl.serial_bit;
			assign nib_in = '0;
		end else begin : g_next
			assign bit_in = carry_w[i-1];
			assign nib_in = digit_w[i-1];
		end

		iff_digit_cell u_cell (
			.clk      (clk),
			.op       (ctrl.op),
			.bit_in   (bit_in),
			.nib_in   (nib_in),
			.load_nib (load_vec[i*DIGIT_W +: DIGIT_W]),
			.digit    (digit_w[i]),
			.carry    (carry_w[i])
		);
	end

	assign top_digit = digit_w[N_CELLS-1];

endmodule

>>> sv/integer_field_formatter_unit.sv
// Decimal items pass bit-serially through the digit chain in ST_DABBLE, hexadecimal items are
// loaded into it directly; ST_NORM then strips leading zero digits (chain of 10 cells at 32 bits),
// ST_SETUP sizes the field, and ST_EMIT sends one character per cycle unless the output stalls.
// Items are formatted one at a time: no new request is taken while an item is in progress.
// The input is taken again as soon as the last character sits in the output register.
// Reset clears the controller and the output valid; the digit chain holds no reset state.
module integer_field_formatter_unit #(
	parameter int FIELD_MAX  = iff_pkg::FIELD_MAX_DEF,
	parameter int VALUE_BITS = iff_pkg::VALUE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	iff_req_if.sink   fmt_req,
	iff_chr_if.source fmt_chars
);
	import iff_pkg::*;

	localparam int NDIG   = cell_count(VALUE_BITS);
	localparam int CNT_W  = $clog2(VALUE_BITS + 1);
	localparam int ND_W   = $clog2(NDIG + 1);
	localparam int LOAD_W = NDIG * DIGIT_W;
	localparam logic [WIDTH_W-1:0] FW_MAX = WIDTH_W'(FIELD_MAX);

	fmt_state_t state_q, state_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic [VALUE_BITS-1:0] mag_q;
	logic                  kind_q, neg_q, none_q;
	logic [WIDTH_W-1:0]    fw_q, prec_q;
	logic [ND_W-1:0]       nd_q;
	logic [POS_W-1:0]      pad_end_q, sign_end_q, zero_end_q, total_q, pos_q;
	logic                  ov_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;

	logic                  accept;
	logic [VALUE_BITS-1:0] raw, mag_in;
	logic                  neg_in;
	logic [WIDTH_W-1:0]    fw_in, prec_in;
	logic [LOAD_W-1:0]     load_vec;
	chain_ctrl_t           ctrl;
	logic [DIGIT_W-1:0]    top_digit;
	logic                  dabble_end, norm_done;
	logic                  zero_digit;
	logic [ND_W-1:0]       nd_eff;
	logic [POS_W-1:0]      nd_pos, len, body, pad, sign_end_d, zero_end_d, total_d;
	logic                  char_load, last_next, digit_phase;
	logic [CHAR_W-1:0]     char_next;

	// Request decode: operand magnitude, sign and saturated field settings.
	assign accept = fmt_req.valid && fmt_req.ready;
	assign raw    = fmt_req.value[VALUE_BITS-1:0];
	assign neg_in = !fmt_req.kind && raw[VALUE_BITS-1];
	assign mag_in = neg_in ? VALUE_BITS'(~raw + 1'b1) : raw;
	assign fw_in  = (fmt_req.width > FW_MAX) ? FW_MAX : fmt_req.width;
	assign prec_in = fmt_req.precision[PREC_W-1] ? '0 :
		((fmt_req.precision[WIDTH_W-1:0] > FW_MAX) ? FW_MAX :
			fmt_req.precision[WIDTH_W-1:0]);
	assign load_vec = fmt_req.kind ? LOAD_W'(raw) : '0;

	// Chain of digit cells.
	iff_digit_chain #(
		.N_CELLS (NDIG)
	) u_chain (
		.clk       (clk),
		.ctrl      (ctrl),
		.load_vec  (load_vec),
		.top_digit (top_digit)
	);

	// Phase end conditions.
	assign dabble_end = (cnt_q == CNT_W'(VALUE_BITS - 1));
	assign norm_done  = (top_digit != '0) || (cnt_q == CNT_W'(NDIG));

	// Field layout: spaces, sign, leading zeros, then the significant digits.
	always_comb begin
		zero_digit = (nd_q == '0) && (none_q || (prec_q != '0));
		nd_eff     = zero_digit ? ND_W'(1) : nd_q;
		nd_pos     = POS_W'(nd_eff);
		len        = (POS_W'(prec_q) > nd_pos) ? POS_W'(prec_q) : nd_pos;
		body       = len + POS_W'(neg_q);
		pad        = (POS_W'(fw_q) > body) ? POS_W'(fw_q) - body : '0;
		sign_end_d = pad + POS_W'(neg_q);
		zero_end_d = sign_end_d + (len - nd_pos);
		total_d    = pad + body;
	end

	// Character at the current position of the field.
	always_comb begin
		char_load   = (state_q == ST_EMIT) && (!ov_q || fmt_chars.ready);
		last_next   = (pos_q == total_q - 1'b1);
		digit_phase = (pos_q >= zero_end_q);
		if (pos_q < pad_end_q) begin
			char_next = CHAR_SPACE;
		end else if (pos_q < sign_end_q) begin
			char_next = CHAR_MINUS;
		end else if (!digit_phase) begin
			char_next = CHAR_ZERO;
		end else begin
			char_next = digit_char(top_digit);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = fmt_req.kind ? ST_NORM : ST_DABBLE;
				end
			end
			ST_DABBLE: begin
				if (dabble_end) begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				if (norm_done) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_d = (total_d == '0) ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				if (char_load && last_next) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller outputs: request ready, chain operation and phase counter.
	always_comb begin
		fmt_req.ready   = 1'b0;
		ctrl.op         = CH_HOLD;
		ctrl.serial_bit = mag_q[VALUE_BITS-1];
		cnt_d           = '0;
		case (state_q)
			ST_IDLE: begin
				fmt_req.ready = 1'b1;
				if (accept) begin
					ctrl.op = CH_LOAD;
				end
			end
			ST_DABBLE: begin
				ctrl.op = CH_DABBLE;
				cnt_d   = dabble_end ? '0 : cnt_q + 1'b1;
			end
			ST_NORM: begin
				if (!norm_done) begin
					ctrl.op = CH_SHIFT;
					cnt_d   = cnt_q + 1'b1;
				end
			end
			ST_EMIT: begin
				if (char_load && digit_phase) begin
					ctrl.op = CH_SHIFT;
				end
			end
			default: begin
				ctrl.op = CH_HOLD;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pos_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (state_q == ST_SETUP) begin
				pos_q <= '0;
			end else if (char_load) begin
				pos_q <= pos_q + 1'b1;
			end
			if (char_load) begin
				ov_q <= 1'b1;
			end else if (fmt_chars.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Operand and field layout registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q  <= mag_in;
			kind_q <= fmt_req.kind;
			neg_q  <= neg_in;
			none_q <= fmt_req.precision[PREC_W-1];
			fw_q   <= fw_in;
			prec_q <= prec_in;
		end else if (state_q == ST_DABBLE) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end
		if ((state_q == ST_NORM) && norm_done) begin
			nd_q <= ND_W'(NDIG) - cnt_q[ND_W-1:0];
		end
		if (state_q == ST_SETUP) begin
			pad_end_q  <= pad;
			sign_end_q <= sign_end_d;
			zero_end_q <= zero_end_d;
			total_q    <= total_d;
		end
	end

	// Output register for the response item.
	always_ff @(posedge clk) begin
		if (char_load) begin
			char_q <= char_next;
			last_q <= last_next;
		end
	end

	assign fmt_chars.valid     = ov_q;
	assign fmt_chars.text_char = char_q;
	assign fmt_chars.last_char = last_q;

	// Checks on the formatter's own sequencing.
	a_pad_space: assert property (@(posedge clk) disable iff (!arst_n)
		char_load && (pos_q < pad_end_q) |=> fmt_chars.text_char == CHAR_SPACE)
		else $error("padding position did not produce a space");

	a_bcd_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && !kind_q |-> top_digit <= 4'd9)
		else $error("decimal chain holds a digit above nine");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		char_load && last_next |=> state_q == ST_IDLE)
		else $error("controller did not return to idle after the last character");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> pos_q < total_q)
		else $error("character position ran past the field length");

endmodule
